FILE: rtl/rth_pkg.sv
`timescale 1ns / 1ps

package rth_pkg;

  localparam int CHAN_W       = 8;
  localparam int HUE_NUM_W    = 11;
  localparam int HUE_BITS_DEF = 16;
  localparam int SAT_BITS_DEF = 16;
  localparam int QUEUE_DEPTH  = 4;

  typedef struct packed {
    logic [CHAN_W-1:0]    value;
    logic [CHAN_W-1:0]    span;
    logic                 gray;
    logic [HUE_NUM_W-1:0] hue_num;
    logic [HUE_NUM_W-1:0] hue_den;
  } rth_item_t;

endpackage

FILE: rtl/rth_front.sv
`timescale 1ns / 1ps

module rth_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [3*rth_pkg::CHAN_W-1:0]       s_tdata,
  output logic                               push_valid,
  input  logic                               push_ready,
  output rth_pkg::rth_item_t                 push_item
);
  import rth_pkg::*;

  logic [CHAN_W-1:0]    red;
  logic [CHAN_W-1:0]    green;
  logic [CHAN_W-1:0]    blue;
  logic                 red_max;
  logic                 green_max;
  logic [CHAN_W-1:0]    most;
  logic [CHAN_W-1:0]    least;
  logic [CHAN_W-1:0]    span;
  logic                 gray;
  logic [11:0]          span6;
  logic signed [11:0]   raw;
  logic [11:0]          fixed;
  logic                 pvalid;
  rth_item_t            item;
  rth_item_t            item_next;

  assign red   = s_tdata[CHAN_W-1:0];
  assign green = s_tdata[2*CHAN_W-1:CHAN_W];
  assign blue  = s_tdata[3*CHAN_W-1:2*CHAN_W];

  always_comb begin
    red_max   = (red >= green) && (red >= blue);
    green_max = !red_max && (green >= blue);
    if (red_max) begin
      most = red;
    end else if (green_max) begin
      most = green;
    end else begin
      most = blue;
    end
    least = red;
    if (green < least) begin
      least = green;
    end
    if (blue < least) begin
      least = blue;
    end
    span  = most - least;
    gray  = (span == '0);
    span6 = {2'b00, span, 2'b00} + {3'b000, span, 1'b0};
    if (red_max) begin
      raw = $signed({4'b0000, green}) - $signed({4'b0000, blue});
    end else if (green_max) begin
      raw = $signed({3'b000, span, 1'b0}) + $signed({4'b0000, blue})
            - $signed({4'b0000, red});
    end else begin
      raw = $signed({2'b00, span, 2'b00}) + $signed({4'b0000, red})
            - $signed({4'b0000, green});
    end
    if (raw < 0) begin
      fixed = $unsigned(raw) + span6;
    end else begin
      fixed = $unsigned(raw);
    end
    item_next.value   = most;
    item_next.span    = span;
    item_next.gray    = gray;
    item_next.hue_num = gray ? '0 : fixed[HUE_NUM_W-1:0];
    item_next.hue_den = gray ? HUE_NUM_W'(1) : span6[HUE_NUM_W-1:0];
  end

  assign s_tready   = !pvalid || push_ready;
  assign push_valid = pvalid;
  assign push_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= 1'b0;
    end else if (s_tready) begin
      pvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item <= item_next;
    end
  end

endmodule

FILE: rtl/rth_fifo.sv
`timescale 1ns / 1ps

module rth_fifo #(
  parameter int DEPTH = rth_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  rth_pkg::rth_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output rth_pkg::rth_item_t pop_item
);
  import rth_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  rth_item_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != (PTR_W + 1)'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: rtl/rth_div.sv
`timescale 1ns / 1ps

module rth_div #(
  parameter int DVD_W = 27,
  parameter int DVS_W = 11,
  parameter int STEPS = 16
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [STEPS-1:0] quotient
);

  localparam int EXT_W = STEPS + DVS_W;

  logic [EXT_W-1:0] ext;
  logic [DVS_W-1:0] rem_q [STEPS-1];
  logic [STEPS-1:0] low_q [STEPS-1];
  logic [DVS_W-1:0] dvs_q [STEPS-1];
  logic [STEPS-1:0] quo_q [STEPS];

  assign ext      = EXT_W'(dividend);
  assign quotient = quo_q[STEPS-1];

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic [DVS_W-1:0] cur_rem;
    logic [STEPS-1:0] cur_low;
    logic [STEPS-1:0] cur_quo;
    logic [DVS_W-1:0] cur_dvs;
    logic [DVS_W:0]   trial;
    logic             ge;

    if (s == 0) begin : g_first
      always_comb begin
        cur_rem = ext[EXT_W-1:STEPS];
        cur_low = ext[STEPS-1:0];
        cur_quo = '0;
        cur_dvs = divisor;
      end
    end else begin : g_rest
      always_comb begin
        cur_rem = rem_q[s-1];
        cur_low = low_q[s-1];
        cur_quo = quo_q[s-1];
        cur_dvs = dvs_q[s-1];
      end
    end

    assign trial = {cur_rem, cur_low[STEPS-1]};
    assign ge    = (trial >= {1'b0, cur_dvs});

    always_ff @(posedge clk) begin
      if (en) begin
        quo_q[s] <= {cur_quo[STEPS-2:0], ge};
      end
    end

    if (s < STEPS - 1) begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[s] <= ge ? DVS_W'(trial - {1'b0, cur_dvs}) : trial[DVS_W-1:0];
          low_q[s] <= {cur_low[STEPS-2:0], 1'b0};
          dvs_q[s] <= cur_dvs;
        end
      end
    end
  end

endmodule

FILE: rtl/rth_back.sv
`timescale 1ns / 1ps

module rth_back #(
  parameter int HUE_BITS = rth_pkg::HUE_BITS_DEF,
  parameter int SAT_BITS = rth_pkg::SAT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  rth_pkg::rth_item_t          pop_item,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [HUE_BITS-1:0]         hue,
  output logic [SAT_BITS-1:0]         sat,
  output logic [rth_pkg::CHAN_W-1:0]  value
);
  import rth_pkg::*;

  localparam int STEPS   = (HUE_BITS > SAT_BITS) ? HUE_BITS : SAT_BITS;
  localparam int HDVD_W  = HUE_NUM_W + HUE_BITS;
  localparam int SDVD_W  = CHAN_W + SAT_BITS;

  logic                en;
  logic [STEPS-1:0]    vld;
  logic [CHAN_W-1:0]   val_q [STEPS];
  logic [HDVD_W-1:0]   hue_dvd;
  logic [SDVD_W-1:0]   sat_dvd;
  logic [HUE_NUM_W-1:0] sat_dvs;
  logic [STEPS-1:0]    hue_quo;
  logic [STEPS-1:0]    sat_quo;

  assign en        = !vld[STEPS-1] || m_tready;
  assign pop_ready = en;

  assign hue_dvd = {pop_item.hue_num, HUE_BITS'(0)};
  assign sat_dvd = {pop_item.span, SAT_BITS'(0)} - SDVD_W'(pop_item.span);
  assign sat_dvs = pop_item.gray ? HUE_NUM_W'(1) : HUE_NUM_W'(pop_item.value);

  rth_div #(
    .DVD_W (HDVD_W),
    .DVS_W (HUE_NUM_W),
    .STEPS (STEPS)
  ) u_hue_div (
    .clk      (clk),
    .en       (en),
    .dividend (hue_dvd),
    .divisor  (pop_item.hue_den),
    .quotient (hue_quo)
  );

  rth_div #(
    .DVD_W (SDVD_W),
    .DVS_W (HUE_NUM_W),
    .STEPS (STEPS)
  ) u_sat_div (
    .clk      (clk),
    .en       (en),
    .dividend (sat_dvd),
    .divisor  (sat_dvs),
    .quotient (sat_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STEPS-2:0], pop_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_q[0] <= pop_item.value;
      for (int i = 1; i < STEPS; i++) begin
        val_q[i] <= val_q[i-1];
      end
    end
  end

  assign m_tvalid = vld[STEPS-1];
  assign hue      = hue_quo[HUE_BITS-1:0];
  assign sat      = sat_quo[SAT_BITS-1:0];
  assign value    = val_q[STEPS-1];

  a_black_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (value == '0) |-> (hue == '0) && (sat == '0))
    else $error("black item with nonzero hue or saturation");

  a_gray_hue: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (sat == '0) |-> (hue == '0))
    else $error("zero saturation item with nonzero hue");

  a_pop_enters: assert property (@(posedge clk) disable iff (rst)
    pop_valid && pop_ready |=> vld[0])
    else $error("popped item did not enter the divider pipeline");

endmodule

FILE: rtl/rgb_to_hsv_converter_core.sv
`timescale 1ns / 1ps
// Pipeline: one classify register, one queue slot, then one register per quotient
//   bit in the restoring divider pipeline.
// Throughput: one pixel per cycle while m_tready does not stall the output; the
//   divider steps are fully pipelined.
// Reset: synchronous rst clears the valid flags, queue pointers and queue count only.

module rgb_to_hsv_converter_core #(
  parameter int HUE_BITS = rth_pkg::HUE_BITS_DEF,
  parameter int SAT_BITS = rth_pkg::SAT_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  // red_in [7:0], green_in [15:8], blue_in [23:16]
  input  logic [3*rth_pkg::CHAN_W-1:0]                  s_tdata,
  output logic                                          m_tvalid,
  input  logic                                          m_tready,
  // hue_out, saturation_out, value_out, zero fill to whole bytes
  output logic [((HUE_BITS+SAT_BITS+rth_pkg::CHAN_W+7)/8)*8-1:0] m_tdata
);
  import rth_pkg::*;

  localparam int OUT_W = ((HUE_BITS + SAT_BITS + CHAN_W + 7) / 8) * 8;

  logic              push_valid;
  logic              push_ready;
  rth_item_t         push_item;
  logic              pop_valid;
  logic              pop_ready;
  rth_item_t         pop_item;
  logic [HUE_BITS-1:0] hue;
  logic [SAT_BITS-1:0] sat;
  logic [CHAN_W-1:0]   value;

  rth_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  rth_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  rth_back #(
    .HUE_BITS (HUE_BITS),
    .SAT_BITS (SAT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .hue       (hue),
    .sat       (sat),
    .value     (value)
  );

  assign m_tdata = OUT_W'({value, sat, hue});

endmodule

FILE: tb/sv/rgb_to_hsv_converter_core_test.sv
`timescale 1ns / 1ps

module rgb_to_hsv_converter_core_test;

  localparam int HUE_W          = 16;
  localparam int SAT_W          = 16;
  localparam int CH_W           = rth_pkg::CHAN_W;
  localparam int OUT_W          = ((HUE_W + SAT_W + CH_W + 7) / 8) * 8;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int PRINT_LIMIT    = 20;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [CH_W-1:0]  value;
  } hsv_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [3*CH_W-1:0] s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;

  logic [3*CH_W-1:0] pixel_queue[$];
  hsv_t              hsv_expected[$];
  hsv_t              want;
  hsv_t              leftover;
  int                pixels_issued = 0;
  int                pixels_taken = 0;
  int                results_seen = 0;
  int                mismatches = 0;
  int                cycles = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  logic              hold_request = 1'b0;
  int                holdoff_cnt = 0;
  logic              holding;

  rgb_to_hsv_converter_core #(
    .HUE_BITS(HUE_W),
    .SAT_BITS(SAT_W)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic hsv_t hsv_of_pixel(input logic [CH_W-1:0] r, g, b);
    hsv_t            res;
    logic [CH_W-1:0] most;
    logic [CH_W-1:0] least;
    int              span;
    int              num;
    most = r;
    if (g > most) most = g;
    if (b > most) most = b;
    least = r;
    if (g < least) least = g;
    if (b < least) least = b;
    span = int'(most) - int'(least);
    res.value = most;
    res.hue = '0;
    res.sat = '0;
    if (span != 0) begin
      if (most == r) begin
        num = int'(g) - int'(b);
      end else if (most == g) begin
        num = 2 * span + int'(b) - int'(r);
      end else begin
        num = 4 * span + int'(r) - int'(g);
      end
      if (num < 0) num += 6 * span;
      res.hue = HUE_W'((longint'(num) << HUE_W) / longint'(6 * span));
      res.sat = SAT_W'((longint'(span) * ((longint'(1) << SAT_W) - 1)) / longint'(most));
    end
    return res;
  endfunction

  function automatic logic [CH_W-1:0] corner_byte();
    case ($urandom_range(0, 4))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd254;
      3: return 8'd255;
      default: return CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [3*CH_W-1:0] random_pixel();
    logic [CH_W-1:0] r, g, b;
    int              base;
    r = CH_W'($urandom_range(0, 255));
    g = CH_W'($urandom_range(0, 255));
    b = CH_W'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      5: begin
        base = $urandom_range(2, 253);
        r = CH_W'(base + $urandom_range(0, 4) - 2);
        g = CH_W'(base + $urandom_range(0, 4) - 2);
        b = CH_W'(base + $urandom_range(0, 4) - 2);
      end
      6: begin
        case ($urandom_range(0, 2))
          0: g = r;
          1: b = g;
          default: b = r;
        endcase
      end
      7: begin
        r = corner_byte();
        g = corner_byte();
        b = corner_byte();
      end
      8: begin
        r = CH_W'($urandom_range(0, 3));
        g = CH_W'($urandom_range(0, 3));
        b = CH_W'($urandom_range(0, 3));
      end
      default: ;
    endcase
    return {b, g, r};
  endfunction

  task automatic queue_pixel(input logic [CH_W-1:0] r, g, b);
    pixel_queue.push_back({b, g, r});
    pixels_issued++;
  endtask

  task automatic wait_drained();
    while (results_seen < pixels_issued) @(posedge clk);
  endtask

  task automatic run_phase(input int count, input int send_pct, input int recv_pct);
    @(posedge clk);
    send_idle_pct  <= send_pct;
    recv_stall_pct <= recv_pct;
    for (int i = 0; i < count; i++) begin
      pixel_queue.push_back(random_pixel());
      pixels_issued++;
    end
    wait_drained();
  endtask

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    if (mismatches < PRINT_LIMIT)
      $display("mismatch at result %0d: %s got %0d expected %0d",
               results_seen, what, got, exp_val);
    mismatches++;
  endtask

  // drive pixels, hold each until taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        hsv_expected.push_back(hsv_of_pixel(s_tdata[CH_W-1:0], s_tdata[2*CH_W-1:CH_W],
                                            s_tdata[3*CH_W-1:2*CH_W]));
        pixels_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pixel_queue.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      holdoff_cnt <= 0;
    end else if (hold_request && holdoff_cnt != HOLDOFF_CYCLES) begin
      holdoff_cnt <= holdoff_cnt + 1;
    end
  end

  assign holding = hold_request && holdoff_cnt != HOLDOFF_CYCLES;

  // take HSV items and check each against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (hsv_expected.size() == 0) begin
          report_mismatch("unexpected item, hue", int'(m_tdata[HUE_W-1:0]), -1);
        end else begin
          want = hsv_expected.pop_front();
          if (m_tdata[HUE_W-1:0] !== want.hue)
            report_mismatch("hue", int'(m_tdata[HUE_W-1:0]), int'(want.hue));
          if (m_tdata[HUE_W+SAT_W-1:HUE_W] !== want.sat)
            report_mismatch("saturation", int'(m_tdata[HUE_W+SAT_W-1:HUE_W]),
                            int'(want.sat));
          if (m_tdata[HUE_W+SAT_W+CH_W-1:HUE_W+SAT_W] !== want.value)
            report_mismatch("value", int'(m_tdata[HUE_W+SAT_W+CH_W-1:HUE_W+SAT_W]),
                            int'(want.value));
        end
        results_seen++;
      end
      m_tready <= !holding && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d items checked",
               cycles, results_seen, pixels_issued);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    queue_pixel(8'd0,   8'd0,   8'd0);
    queue_pixel(8'd255, 8'd255, 8'd255);
    queue_pixel(8'd128, 8'd128, 8'd128);
    queue_pixel(8'd1,   8'd1,   8'd1);
    queue_pixel(8'd255, 8'd0,   8'd0);
    queue_pixel(8'd0,   8'd255, 8'd0);
    queue_pixel(8'd0,   8'd0,   8'd255);
    queue_pixel(8'd255, 8'd255, 8'd0);
    queue_pixel(8'd0,   8'd255, 8'd255);
    queue_pixel(8'd255, 8'd0,   8'd255);
    queue_pixel(8'd255, 8'd0,   8'd1);
    queue_pixel(8'd255, 8'd1,   8'd0);
    queue_pixel(8'd1,   8'd0,   8'd0);
    queue_pixel(8'd0,   8'd1,   8'd0);
    queue_pixel(8'd0,   8'd0,   8'd1);
    queue_pixel(8'd1,   8'd255, 8'd0);
    queue_pixel(8'd0,   8'd254, 8'd255);
    queue_pixel(8'd254, 8'd0,   8'd255);
    queue_pixel(8'd255, 8'd254, 8'd254);
    queue_pixel(8'd10,  8'd20,  8'd30);
    queue_pixel(8'd200, 8'd100, 8'd50);
    queue_pixel(8'd170, 8'd85,  8'd0);
    wait_drained();

    run_phase(340, 0, 0);
    run_phase(340, 55, 0);
    run_phase(340, 0, 55);
    run_phase(340, 24, 24);

    @(posedge clk);
    hold_request <= 1'b1;
    run_phase(150, 0, 0);

    repeat (40) @(posedge clk);
    while (hsv_expected.size() != 0) begin
      leftover = hsv_expected.pop_front();
      report_mismatch("missing item, hue", -1, int'(leftover.hue));
    end

    $display("checked %0d HSV items from %0d pixels: directed corners, gray and tie cases,",
             results_seen, pixels_taken);
    $display("random pixels under four idle mixes and a %0d-cycle output hold-off",
             HOLDOFF_CYCLES);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
